// ===== rtl/i2crf_pkg.sv =====
// ============================================================================
// i2crf_pkg
// Shared types and constants for the I2C slave register file with cipher.
// ============================================================================
package i2crf_pkg;

    localparam int REG_COUNT     = 256;
    localparam int ADDR_W        = $clog2(REG_COUNT);
    localparam int CIPHER_PERIOD = 8;
    localparam int KEY_IDX_W     = $clog2(CIPHER_PERIOD);
    localparam int KEY_W         = 8 * CIPHER_PERIOD;

    // Request codes
    localparam logic [2:0] REQ_WR_ADDR   = 3'd0;
    localparam logic [2:0] REQ_RX_DATA   = 3'd1;
    localparam logic [2:0] REQ_STOP      = 3'd2;
    localparam logic [2:0] REQ_RD_ADDR   = 3'd3;
    localparam logic [2:0] REQ_RD_NEXT   = 3'd4;
    localparam logic [2:0] REQ_HOST_WR   = 3'd5;

    localparam logic [7:0] CIPHER_ON_VALUE  = 8'hAA;
    localparam logic [7:0] CIPHER_CTRL_ADDR = 8'hF0;
    localparam logic [7:0] KEY_BLOCK_LOW    = 8'h4C;
    localparam logic [7:0] KEY_BLOCK_END    = 8'h50;
    localparam logic [7:0] SAMPLE_LIMIT     = 8'h06;

    // APB register map: byte address 8*i
    localparam int          PADDR_W   = 4;
    localparam int          PDATA_W   = 64;
    localparam logic        REG_FT    = 1'b0;
    localparam logic        REG_SB    = 1'b1;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] host_addr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       sample_request;
        logic       write_done;
        logic [7:0] write_start_addr;
        logic [7:0] write_length;
        logic       key_block_done;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] ft_bytes;
        logic [KEY_W-1:0] sb_bytes;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch item and launch register file read
        logic exec;      // apply item, load result register
    } dp_cmd_t;

endpackage

// ===== rtl/i2crf_apb.sv =====
// ============================================================================
// i2crf_apb
// APB configuration registers holding the additive and xor key bytes.
// ============================================================================
module i2crf_apb
    import i2crf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [KEY_W-1:0] ft_reg;
    logic [KEY_W-1:0] sb_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // Registers are 8 bytes apart; bit 3 picks the register.
    assign reg_sel = paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_reg <= '0;
            sb_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_FT:  ft_reg <= pwdata[KEY_W-1:0];
                REG_SB:  sb_reg <= pwdata[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FT:  prdata = ft_reg;
            REG_SB:  prdata = sb_reg;
            default: prdata = '0;
        endcase
    end

    assign cfg.ft_bytes = ft_reg;
    assign cfg.sb_bytes = sb_reg;

endmodule

// ===== rtl/i2crf_ctrl.sv =====
// ============================================================================
// i2crf_ctrl
// Controller: accepts one transaction, runs the execute cycle, owns the
// result handshake.
// ============================================================================
module i2crf_ctrl
    import i2crf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // A new item may enter while the previous result is being taken.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.exec)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/i2crf_dp.sv =====
// ============================================================================
// i2crf_dp
// Datapath: register file, pointer, transfer count, cipher and result
// register.
// ============================================================================
module i2crf_dp
    import i2crf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  in_item_t  in_item,
    input  cfg_t      cfg,
    output out_item_t out_item
);

    logic [7:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [REG_COUNT-1:0] vld_next;

    in_item_t    item_reg;
    logic [7:0]  rdata_reg;
    logic        rvld_reg;
    logic [7:0]  rd_byte;

    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic              pset_reg;
    logic              pset_next;
    logic [7:0]        cnt_reg;
    logic [7:0]        cnt_next;
    logic              cipher_reg;
    logic              cipher_next;

    out_item_t   res_reg;
    out_item_t   res_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    logic [KEY_IDX_W-1:0] kidx;
    logic [7:0]           ft_k;
    logic [7:0]           sb_k;
    logic [7:0]           start;
    logic [8:0]           span_end;

    assign kidx = ptr_reg[KEY_IDX_W-1:0];
    assign ft_k = cfg.ft_bytes[8*kidx +: 8];
    assign sb_k = cfg.sb_bytes[8*kidx +: 8];

    // Entries never written read as zero.
    assign rd_byte  = rvld_reg ? rdata_reg : 8'h00;
    assign start    = ptr_reg - cnt_reg;
    assign span_end = {1'b0, start} + {1'b0, cnt_reg};

    always_comb
    begin
        ptr_next    = ptr_reg;
        pset_next   = pset_reg;
        cnt_next    = cnt_reg;
        res_next    = '0;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = item_reg.data_byte;

        case (item_reg.req_type) inside
            REQ_WR_ADDR: pset_next = 1'b0;
            REQ_RX_DATA:
            begin
                if (pset_reg)
                begin
                    we = 1'b1;
                    if (cipher_reg && (ptr_reg != CIPHER_CTRL_ADDR))
                        wdata = (item_reg.data_byte ^ sb_k) + ft_k;
                    ptr_next = ptr_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    ptr_next  = item_reg.data_byte;
                    pset_next = 1'b1;
                    cnt_next  = '0;
                end
            end
            REQ_STOP:
            begin
                res_next.write_done       = 1'b1;
                res_next.write_start_addr = start;
                res_next.write_length     = cnt_reg;
                res_next.key_block_done   = (start >= KEY_BLOCK_LOW)
                                         && (start < KEY_BLOCK_END)
                                         && (span_end == {1'b0, KEY_BLOCK_END});
            end
            REQ_RD_ADDR, REQ_RD_NEXT:
            begin
                res_next.tx_valid = 1'b1;
                res_next.tx_byte  = cipher_reg ? ((rd_byte - ft_k) ^ sb_k) : rd_byte;
                ptr_next          = ptr_reg + 1'b1;
                if (item_reg.req_type == REQ_RD_ADDR)
                begin
                    res_next.sample_request = (ptr_reg < SAMPLE_LIMIT);
                    cnt_next                = 8'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            REQ_HOST_WR:
            begin
                we    = 1'b1;
                waddr = item_reg.host_addr;
            end
            default: ;
        endcase
    end

    // Cipher enable mirrors whether the control register holds the on value.
    always_comb
    begin
        cipher_next = cipher_reg;
        if (we && (waddr == CIPHER_CTRL_ADDR))
            cipher_next = (wdata == CIPHER_ON_VALUE);
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (we)
            vld_next[waddr] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
            mem[waddr] <= wdata;
        if (cmd.capture)
            rdata_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
            rvld_reg <= vld_reg[ptr_reg];
        end
        if (cmd.exec)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            ptr_reg    <= '0;
            pset_reg   <= 1'b0;
            cnt_reg    <= '0;
            cipher_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            vld_reg    <= vld_next;
            ptr_reg    <= ptr_next;
            pset_reg   <= pset_next;
            cnt_reg    <= cnt_next;
            cipher_reg <= cipher_next;
        end
    end

    assign out_item = res_reg;

endmodule

// ===== rtl/i2c_slave_register_file_cipher.sv =====
// ============================================================================
// i2c_slave_register_file_cipher
// Byte-level I2C slave register file with auto-increment pointer and cipher.
// ============================================================================
// Usage:
//   in_valid/in_ready/in_item carries one bus or host event per transaction;
//   out_valid/out_ready/out_item returns exactly one result per event.
//   The user must write ft_bytes/sb_bytes over the APB port (0x0, 0x8) only
//   while the block is idle, which it does not enforce; pready is tied high.
// Sequence: the accept cycle latches the item and launches the register
//   file read; the execute/write cycle then applies it and loads the output
//   register. No new transaction is taken until the execute cycle is done.
// Reset: all register file entries read as zero, pointer and count clear,
//   cipher off, keys zero. No clearing pass is needed: per-entry valid bits
//   are cleared at once.
// Stall: a held result stays in the output register. The next item is taken
//   in the cycle the result is taken, else input waits until it drains.
// ============================================================================
module i2c_slave_register_file_cipher
    import i2crf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    i2crf_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2crf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    i2crf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .cfg      (cfg),
        .out_item (out_item)
    );

    // One transaction in flight: no accept in the cycle after an accept.
    a_single_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a transaction during execute");

    // Every accepted transaction produces a result once the execute state has loaded the output register.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("result missing after accepted transaction");

    // Transmit byte is zero unless it is a read result.
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.tx_valid) |-> (out_item.tx_byte == 8'h00))
        else $error("tx_byte set without tx_valid");

    // Write report fields are zero unless a stop is reported.
    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.write_done) |->
        (out_item.write_length == 8'h00 && out_item.write_start_addr == 8'h00
         && !out_item.key_block_done))
        else $error("write report set without write_done");

endmodule
